FILE: rtl/core/dcla_pkg.sv
// ----------------------------------------------------------------------------
// dcla_pkg: shared types and constants of the DVFS clock lock arbiter
// Widths, opcode, status and register codes, and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package dcla_pkg;

    // Sizes
    localparam int LOCK_TYPES  = 8;
    localparam int TABLE_DEPTH = 16;
    localparam int CLOCK_BITS  = 22;

    // Field widths
    localparam int OP_W     = 3;
    localparam int LT_IN_W  = 4;
    localparam int TIX_IN_W = 4;
    localparam int TE_W     = 5;
    localparam int LVL_W    = 5;
    localparam int STAT_W   = 2;
    localparam int CFGI_W   = 3;

    // Derived index and counter widths
    localparam int TIDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TCNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LIDX_W  = (LOCK_TYPES > 1) ? $clog2(LOCK_TYPES) : 1;
    localparam int CNT_W   = (TCNT_W > LIDX_W) ? TCNT_W : LIDX_W;
    localparam int NCMP_W  = (CNT_W > TE_W) ? CNT_W : TE_W;
    localparam int LTC_W   = LT_IN_W + 1;
    localparam int TIXC_W  = ((TIDX_W > TIX_IN_W) ? TIDX_W : TIX_IN_W) + 1;

    // Stream widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = OP_W;
    localparam int OUT_DATA_W = 96;

    // Register reset values
    localparam logic [TE_W-1:0] TE_RESET = TE_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_CEIL_LOCK    = 3'd0,
        OP_FLOOR_LOCK   = 3'd1,
        OP_CEIL_UNLOCK  = 3'd2,
        OP_FLOOR_UNLOCK = 3'd3,
        OP_TARGET       = 3'd4,
        OP_TABLE_WR     = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CLOCK = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_DVFS_OFF  = 2'd3
    } t_status;

    typedef enum logic [CFGI_W-1:0] {
        CFG_DVFS_EN       = 3'd0,
        CFG_MIN_CLOCK     = 3'd1,
        CFG_MAX_CLOCK     = 3'd2,
        CFG_USE_LIMIT     = 3'd3,
        CFG_LIMIT_CLOCK   = 3'd4,
        CFG_TABLE_ENTRIES = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [OP_W-1:0]       opcode;
        logic [LT_IN_W-1:0]    lock_type;
        logic [CLOCK_BITS-1:0] clock_req;
        logic [TIX_IN_W-1:0]   table_index;
        logic                  power_on;
        logic [CLOCK_BITS-1:0] current_clock;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [CLOCK_BITS-1:0] floor_now;
        logic [CLOCK_BITS-1:0] ceiling_now;
        logic [CLOCK_BITS-1:0] target_clock;
        logic [LVL_W-1:0]      level;
        logic                  retarget_valid;
        logic [CLOCK_BITS-1:0] retarget_clock;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic table_wr;
        logic srch_init;
        logic srch_step;
        logic srch_final;
        logic clamp;
        logic lock_wr;
        logic scan_step;
        logic finish;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    reject;
        logic    en;
        logic    srch_done;
        logic    srch_hit;
        logic    zero_clk;
        logic    scan_last;
        logic    out_busy;
    } t_dp_sts;

endpackage

FILE: rtl/core/dvfs_clock_lock_arbiter.sv
// Flow: an accepted item passes decode, the one-entry-a-cycle operating-point
//   search over up to TABLE_DEPTH entries (run again for a clamped target),
//   the lock scan over the LOCK_TYPES entries, and the output register.
// Throughput: one item at a time; the next item is taken once the result
//   sits in the output register, so a waiting result does not block input.
// Reset: synchronous, active low; registers to defaults, locks cleared,
//   operating-point table left as is.
// ----------------------------------------------------------------------------
// dvfs_clock_lock_arbiter: floor and ceiling clock lock arbiter
// Validates lock requests against the operating-point table, keeps the
// effective floor and ceiling, and clamps target clocks to them.
// ----------------------------------------------------------------------------
module dvfs_clock_lock_arbiter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dcla_pkg::CFGI_W-1:0]       i_cfg_index,
    input  logic [dcla_pkg::CLOCK_BITS-1:0]   i_cfg_data,
    // input item stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // lock_type[3:0], clock_req[25:4], table_index[29:26], power_on[30],
    // current_clock[52:31], zero[55:53]
    input  logic [dcla_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // opcode[2:0]
    input  logic [dcla_pkg::IN_USER_W-1:0]    i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status[1:0], floor_now[23:2], ceiling_now[45:24], target_clock[67:46],
    // level[72:68], retarget_valid[73], retarget_clock[95:74]
    output logic [dcla_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    dcla_pkg::t_item   item;
    dcla_pkg::t_result result;
    dcla_pkg::t_dp_cmd cmd;
    dcla_pkg::t_dp_sts sts;

    // Unpack the input item
    assign item.opcode        = i_s_tuser;
    assign item.lock_type     = i_s_tdata[3:0];
    assign item.clock_req     = i_s_tdata[25:4];
    assign item.table_index   = i_s_tdata[29:26];
    assign item.power_on      = i_s_tdata[30];
    assign item.current_clock = i_s_tdata[52:31];

    // Pack the result item
    assign o_m_tdata = {result.retarget_clock, result.retarget_valid, result.level,
                        result.target_clock, result.ceiling_now, result.floor_now,
                        result.status};

    assign o_cfg_ready = 1'b1;

    dcla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dcla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (result),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready)
    );

endmodule

FILE: rtl/core/dcla_ctrl.sv
// ----------------------------------------------------------------------------
// dcla_ctrl: sequencer of the DVFS clock lock arbiter
// Steps one item through decode, table search, lock update, lock scan and
// result hand-off by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module dcla_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dcla_pkg::t_dp_sts i_sts,
    output dcla_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DECODE  = 9'b000000010,
        S_SRCH    = 9'b000000100,
        S_CLAMP   = 9'b000001000,
        S_SRCH_T  = 9'b000010000,
        S_LOCK_WR = 9'b000100000,
        S_SCAN    = 9'b001000000,
        S_FIN     = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   is_lock;

    assign is_lock = (i_sts.op == dcla_pkg::OP_CEIL_LOCK) ||
                     (i_sts.op == dcla_pkg::OP_FLOOR_LOCK);

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.reject) begin
                    n_state = S_OUT;
                end else begin
                    case (i_sts.op)
                        dcla_pkg::OP_CEIL_LOCK, dcla_pkg::OP_FLOOR_LOCK,
                        dcla_pkg::OP_TARGET: begin
                            o_cmd.srch_init = 1'b1;
                            n_state         = S_SRCH;
                        end
                        dcla_pkg::OP_CEIL_UNLOCK, dcla_pkg::OP_FLOOR_UNLOCK: begin
                            n_state = S_LOCK_WR;
                        end
                        dcla_pkg::OP_TABLE_WR: begin
                            o_cmd.table_wr = 1'b1;
                            n_state        = S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_done) begin
                    if (!i_sts.srch_hit) begin
                        n_state = S_OUT;
                    end else if (i_sts.op == dcla_pkg::OP_TARGET) begin
                        n_state = i_sts.en ? S_CLAMP : S_OUT;
                    end else begin
                        n_state = S_LOCK_WR;
                    end
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_SRCH_T;
            end
            S_SRCH_T: begin
                o_cmd.srch_step  = 1'b1;
                o_cmd.srch_final = 1'b1;
                if (i_sts.srch_done) begin
                    n_state = S_OUT;
                end
            end
            S_LOCK_WR: begin
                o_cmd.lock_wr = 1'b1;
                // a zero lock clears the effective lock without a scan
                n_state = (is_lock && i_sts.zero_clk) ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/dcla_dp.sv
// ----------------------------------------------------------------------------
// dcla_dp: datapath of the DVFS clock lock arbiter
// Holds the registers, lock tables, operating-point table, the search and
// scan counter, the working values of one item and the output register.
// ----------------------------------------------------------------------------
module dcla_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [dcla_pkg::CFGI_W-1:0]     i_cfg_index,
    input  logic [dcla_pkg::CLOCK_BITS-1:0] i_cfg_data,
    input  dcla_pkg::t_item               i_item,
    input  dcla_pkg::t_dp_cmd             i_cmd,
    output dcla_pkg::t_dp_sts             o_sts,
    output dcla_pkg::t_result             o_result,
    output logic                          o_out_valid,
    input  logic                          i_out_ready
);

    localparam int CB = dcla_pkg::CLOCK_BITS;

    // Configuration registers
    logic                     r_en;
    logic [CB-1:0]            r_min;
    logic [CB-1:0]            r_max;
    logic                     r_use_limit;
    logic [CB-1:0]            r_limit;
    logic [dcla_pkg::TE_W-1:0] r_te;

    // Stores
    logic [CB-1:0] r_ceil_tab  [dcla_pkg::LOCK_TYPES];
    logic [CB-1:0] r_floor_tab [dcla_pkg::LOCK_TYPES];
    logic [CB-1:0] r_clk_tab   [dcla_pkg::TABLE_DEPTH];
    logic [CB-1:0] r_ceil;
    logic [CB-1:0] r_floor;

    // Working values of the item in flight
    dcla_pkg::t_opcode           r_op;
    logic [dcla_pkg::LT_IN_W-1:0]  r_lt;
    logic [CB-1:0]               r_clk;
    logic [dcla_pkg::TIX_IN_W-1:0] r_tix;
    logic                        r_pwr;
    logic [CB-1:0]               r_cur;
    logic [CB-1:0]               r_key;
    logic [dcla_pkg::CNT_W-1:0]    r_cnt;
    logic                        r_any;
    dcla_pkg::t_status           r_status;
    logic [CB-1:0]               r_tgt;
    logic [dcla_pkg::LVL_W-1:0]    r_lvl;
    logic                        r_rv;
    logic [CB-1:0]               r_rc;

    // Output register
    logic              r_out_valid;
    dcla_pkg::t_result r_out;

    logic [CB-1:0]                  upper;
    logic                           in_range;
    logic [dcla_pkg::NCMP_W-1:0]      te_ext;
    logic [dcla_pkg::NCMP_W-1:0]      n_ext;
    logic                           past_end;
    logic                           match;
    logic                           srch_done;
    logic                           srch_hit;
    logic [dcla_pkg::LIDX_W-1:0]      lt_idx;
    logic [dcla_pkg::LIDX_W-1:0]      scan_idx;
    logic [CB-1:0]                  scan_e;
    logic [dcla_pkg::TIXC_W-1:0]      tix_ext;
    logic                           tix_ok;
    logic                           in_reject;
    logic                           in_bad_lt;
    logic [CB-1:0]                  clamp_v;
    logic [CB-1:0]                  clamp_f;
    dcla_pkg::t_opcode              in_op;

    // Validity window and search bound
    assign upper    = r_use_limit ? r_limit : r_max;
    assign in_range = (r_key >= r_min) && (r_key <= upper);
    assign te_ext   = dcla_pkg::NCMP_W'(r_te);
    assign n_ext    = (te_ext > dcla_pkg::NCMP_W'(dcla_pkg::TABLE_DEPTH)) ?
                      dcla_pkg::NCMP_W'(dcla_pkg::TABLE_DEPTH) : te_ext;
    assign past_end = dcla_pkg::NCMP_W'(r_cnt) >= n_ext;
    assign match    = r_clk_tab[r_cnt[dcla_pkg::TIDX_W-1:0]] == r_key;
    assign srch_hit  = in_range && !past_end && match;
    assign srch_done = !in_range || past_end || match;

    // Lock table access
    assign lt_idx   = r_lt[dcla_pkg::LIDX_W-1:0];
    assign scan_idx = r_cnt[dcla_pkg::LIDX_W-1:0];
    assign scan_e   = r_op[0] ? r_floor_tab[scan_idx] : r_ceil_tab[scan_idx];

    assign tix_ext = dcla_pkg::TIXC_W'(r_tix);
    assign tix_ok  = tix_ext < dcla_pkg::TIXC_W'(dcla_pkg::TABLE_DEPTH);

    // Early reject of lock and unlock items
    assign in_op     = dcla_pkg::t_opcode'(i_item.opcode);
    assign in_bad_lt = {1'b0, i_item.lock_type} >= dcla_pkg::LTC_W'(dcla_pkg::LOCK_TYPES);
    assign in_reject = (i_item.opcode <= dcla_pkg::OP_FLOOR_UNLOCK) &&
                       (!r_en || in_bad_lt);

    // Clamp the target to the floor, then to the ceiling
    always_comb begin
        clamp_f = r_tgt;
        if ((r_floor != '0) && r_pwr && ((r_tgt < r_floor) || (r_cur < r_floor))) begin
            clamp_f = r_floor;
        end
        clamp_v = clamp_f;
        if ((r_ceil != '0) && (clamp_f > r_ceil)) begin
            clamp_v = r_ceil;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= 1'b1;
            r_min       <= '0;
            r_max       <= '1;
            r_use_limit <= 1'b0;
            r_limit     <= '1;
            r_te        <= dcla_pkg::TE_RESET;
        end else if (i_cfg_valid) begin
            unique case (dcla_pkg::t_cfg_idx'(i_cfg_index))
                dcla_pkg::CFG_DVFS_EN:       r_en        <= i_cfg_data[0];
                dcla_pkg::CFG_MIN_CLOCK:     r_min       <= i_cfg_data;
                dcla_pkg::CFG_MAX_CLOCK:     r_max       <= i_cfg_data;
                dcla_pkg::CFG_USE_LIMIT:     r_use_limit <= i_cfg_data[0];
                dcla_pkg::CFG_LIMIT_CLOCK:   r_limit     <= i_cfg_data;
                dcla_pkg::CFG_TABLE_ENTRIES: r_te        <= i_cfg_data[dcla_pkg::TE_W-1:0];
                default: ;
            endcase
        end
    end

    // Load operating-point table
    always_ff @(posedge i_clk) begin
        if (i_cmd.table_wr && tix_ok) begin
            r_clk_tab[tix_ext[dcla_pkg::TIDX_W-1:0]] <= r_clk;
        end
    end

    // Lock tables and effective locks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dcla_pkg::LOCK_TYPES; i++) begin
                r_ceil_tab[i]  <= '0;
                r_floor_tab[i] <= '0;
            end
            r_ceil  <= '0;
            r_floor <= '0;
        end else if (i_cmd.lock_wr) begin
            case (r_op)
                dcla_pkg::OP_CEIL_LOCK: begin
                    r_ceil_tab[lt_idx] <= r_clk;
                    r_ceil             <= r_clk;
                end
                dcla_pkg::OP_FLOOR_LOCK: begin
                    r_floor_tab[lt_idx] <= r_clk;
                    r_floor             <= r_clk;
                end
                dcla_pkg::OP_CEIL_UNLOCK: begin
                    r_ceil_tab[lt_idx] <= '0;
                    r_ceil             <= r_max;
                end
                dcla_pkg::OP_FLOOR_UNLOCK: begin
                    r_floor_tab[lt_idx] <= '0;
                    r_floor             <= r_min;
                end
                default: ;
            endcase
        end else if (i_cmd.scan_step) begin
            // fold one entry: minimum of set ceilings, maximum of floors
            if (r_op[0]) begin
                if (scan_e > r_floor) begin
                    r_floor <= scan_e;
                end
            end else if ((scan_e != '0) && (scan_e < r_ceil)) begin
                r_ceil <= scan_e;
            end
        end else if (i_cmd.finish && !r_any) begin
            // no lock left after an unlock
            if (r_op == dcla_pkg::OP_CEIL_UNLOCK) begin
                r_ceil <= '0;
            end else if (r_op == dcla_pkg::OP_FLOOR_UNLOCK) begin
                r_floor <= '0;
            end
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= in_op;
            r_lt  <= i_item.lock_type;
            r_clk <= i_item.clock_req;
            r_tix <= i_item.table_index;
            r_pwr <= i_item.power_on;
            r_cur <= i_item.current_clock;
        end
    end

    // Search key, counter and scan flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_key <= r_clk;
            r_cnt <= '0;
        end else if (i_cmd.clamp) begin
            r_key <= clamp_v;
            r_cnt <= '0;
        end else if (i_cmd.lock_wr) begin
            r_cnt <= '0;
            r_any <= 1'b0;
        end else if (i_cmd.srch_step || i_cmd.scan_step) begin
            r_cnt <= r_cnt + dcla_pkg::CNT_W'(1);
            if (i_cmd.scan_step && (scan_e != '0)) begin
                r_any <= 1'b1;
            end
        end
    end

    // Result fields of the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= !in_reject ? dcla_pkg::ST_OK :
                        (!r_en ? dcla_pkg::ST_DVFS_OFF : dcla_pkg::ST_BAD_TYPE);
            r_tgt    <= '0;
            r_lvl    <= '1;
            r_rv     <= 1'b0;
            r_rc     <= '0;
        end else if (i_cmd.srch_step && srch_done) begin
            if (i_cmd.srch_final) begin
                r_lvl <= srch_hit ? dcla_pkg::LVL_W'(r_cnt) : '1;
            end else if (!srch_hit) begin
                r_status <= dcla_pkg::ST_BAD_CLOCK;
            end else if (r_op == dcla_pkg::OP_TARGET) begin
                r_tgt <= r_key;
            end
        end else if (i_cmd.clamp) begin
            r_tgt <= clamp_v;
        end else if (i_cmd.finish) begin
            // retarget request of a lock
            if (r_op == dcla_pkg::OP_CEIL_LOCK) begin
                if ((r_ceil != '0) && (r_cur >= r_ceil)) begin
                    r_rv <= 1'b1;
                    r_rc <= r_ceil;
                end
            end else if (r_op == dcla_pkg::OP_FLOOR_LOCK) begin
                if ((r_floor != '0) && (r_cur < r_floor) && (r_floor <= r_ceil)) begin
                    r_rv <= 1'b1;
                    r_rc <= r_floor;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status         <= r_status;
            r_out.floor_now      <= r_floor;
            r_out.ceiling_now    <= r_ceil;
            r_out.target_clock   <= r_tgt;
            r_out.level          <= r_lvl;
            r_out.retarget_valid <= r_rv;
            r_out.retarget_clock <= r_rc;
        end
    end

    assign o_result    = r_out;
    assign o_out_valid = r_out_valid;

    // Status to the controller
    assign o_sts.op        = r_op;
    assign o_sts.reject    = r_status != dcla_pkg::ST_OK;
    assign o_sts.en        = r_en;
    assign o_sts.srch_done = srch_done;
    assign o_sts.srch_hit  = srch_hit;
    assign o_sts.zero_clk  = r_clk == '0;
    assign o_sts.scan_last = r_cnt == dcla_pkg::CNT_W'(dcla_pkg::LOCK_TYPES - 1);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

endmodule

FILE: tb/tb_dvfs_clock_lock_arbiter.sv
// ----------------------------------------------------------------------------
// tb_dvfs_clock_lock_arbiter: self-checking bench of the clock lock arbiter
// Loads the operating-point table, runs directed lock, unlock and target
// items, then random items over several register settings. Each accepted
// item is run through a local arbiter model and the result stream is
// checked field by field against it, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_dvfs_clock_lock_arbiter;

    timeunit 1ns;
    timeprecision 1ps;

    import dcla_pkg::*;

    localparam logic [CLOCK_BITS-1:0] CLK_TOP = {CLOCK_BITS{1'b1}};
    localparam int IDLE_PCT    = 26;
    localparam int SETTLE      = 3 + 2 * TABLE_DEPTH + 8;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 55;
    localparam int CALM_FROM   = 4000;
    localparam int CALM_TO     = 7000;

    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} t_act_kind;

    typedef struct {
        t_act_kind             kind;
        t_item                 item;
        t_cfg_idx              idx;
        logic [CLOCK_BITS-1:0] data;
    } t_action;

    // DUT ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFGI_W-1:0]     i_cfg_index = '0;
    logic [CLOCK_BITS-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic [IN_USER_W-1:0]  i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // Stimulus plan and generation-time view of the block
    t_action               plan_q[$];
    logic [CLOCK_BITS-1:0] plan_table [TABLE_DEPTH];
    logic [TE_W-1:0]       plan_entries = TE_RESET;

    // Arbiter model state
    logic                  dvfs_en     = 1'b1;
    logic [CLOCK_BITS-1:0] min_clk     = '0;
    logic [CLOCK_BITS-1:0] max_clk     = CLK_TOP;
    logic                  use_limit   = 1'b0;
    logic [CLOCK_BITS-1:0] limit_clk   = CLK_TOP;
    logic [TE_W-1:0]       tbl_entries = TE_RESET;
    logic [CLOCK_BITS-1:0] ceil_by_type  [LOCK_TYPES];
    logic [CLOCK_BITS-1:0] floor_by_type [LOCK_TYPES];
    logic [CLOCK_BITS-1:0] op_table      [TABLE_DEPTH];
    logic [CLOCK_BITS-1:0] ceil_eff  = '0;
    logic [CLOCK_BITS-1:0] floor_eff = '0;

    // Results awaited from the block, oldest first
    t_result               awaited_results[$];

    // Driver and monitor bookkeeping
    t_item                 cur_item   = '0;
    logic                  item_hold  = 1'b0;
    logic                  item_taken = 1'b0;
    logic                  cfg_hold   = 1'b0;
    logic                  cfg_taken  = 1'b0;
    t_cfg_idx              cfg_idx_r  = CFG_DVFS_EN;
    logic [CLOCK_BITS-1:0] cfg_data_r = '0;
    int                    settle_cnt = 0;
    int                    cyc        = 0;
    int                    errors     = 0;

    dvfs_clock_lock_arbiter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Lowest table level holding clk within the legal window, -1 if none
    function automatic int lookup_level(input logic [CLOCK_BITS-1:0] clk);
        logic [CLOCK_BITS-1:0] upper;
        int                    n;
        int                    i;
        upper = use_limit ? limit_clk : max_clk;
        n = (tbl_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(tbl_entries);
        if (clk < min_clk || clk > upper) return -1;
        for (i = 0; i < n; i++)
            if (op_table[i] == clk) return i;
        return -1;
    endfunction

    // Apply one item to the arbiter model and return the result it yields
    function automatic t_result arbitrate_item(input t_item it);
        t_result               r;
        int                    lvl;
        logic                  any;
        int                    i;
        logic [LIDX_W-1:0]     lt;
        logic [CLOCK_BITS-1:0] clk;
        logic [CLOCK_BITS-1:0] cur;
        logic [CLOCK_BITS-1:0] tgt;
        r   = '0;
        lvl = -1;
        lt  = it.lock_type[LIDX_W-1:0];
        clk = it.clock_req;
        cur = it.current_clock;
        if (it.opcode <= OP_FLOOR_UNLOCK) begin
            if (!dvfs_en) begin
                r.status = ST_DVFS_OFF;
            end else if (it.lock_type >= LOCK_TYPES) begin
                r.status = ST_BAD_TYPE;
            end else begin
                case (it.opcode)
                    OP_CEIL_LOCK: begin
                        if (lookup_level(clk) < 0) begin
                            r.status = ST_BAD_CLOCK;
                        end else begin
                            ceil_by_type[lt] = clk;
                            ceil_eff = clk;
                            if (clk > 0)
                                for (i = 0; i < LOCK_TYPES; i++)
                                    if (ceil_by_type[i] > 0 && ceil_by_type[i] < ceil_eff)
                                        ceil_eff = ceil_by_type[i];
                            if (ceil_eff > 0 && cur >= ceil_eff) begin
                                r.retarget_valid = 1'b1;
                                r.retarget_clock = ceil_eff;
                            end
                        end
                    end
                    OP_FLOOR_LOCK: begin
                        if (lookup_level(clk) < 0) begin
                            r.status = ST_BAD_CLOCK;
                        end else begin
                            floor_by_type[lt] = clk;
                            floor_eff = clk;
                            if (clk > 0)
                                for (i = 0; i < LOCK_TYPES; i++)
                                    if (floor_by_type[i] > floor_eff)
                                        floor_eff = floor_by_type[i];
                            // a floor retargets only at or below an existing ceiling
                            if (floor_eff > 0 && cur < floor_eff && floor_eff <= ceil_eff) begin
                                r.retarget_valid = 1'b1;
                                r.retarget_clock = floor_eff;
                            end
                        end
                    end
                    OP_CEIL_UNLOCK: begin
                        any = 1'b0;
                        ceil_by_type[lt] = '0;
                        ceil_eff = max_clk;
                        for (i = 0; i < LOCK_TYPES; i++)
                            if (ceil_by_type[i] > 0) begin
                                any = 1'b1;
                                if (ceil_by_type[i] < ceil_eff) ceil_eff = ceil_by_type[i];
                            end
                        if (!any) ceil_eff = '0;
                    end
                    default: begin
                        any = 1'b0;
                        floor_by_type[lt] = '0;
                        floor_eff = min_clk;
                        for (i = 0; i < LOCK_TYPES; i++)
                            if (floor_by_type[i] > 0) begin
                                any = 1'b1;
                                if (floor_by_type[i] > floor_eff) floor_eff = floor_by_type[i];
                            end
                        if (!any) floor_eff = '0;
                    end
                endcase
            end
        end else if (it.opcode == OP_TARGET) begin
            if (lookup_level(clk) < 0) begin
                r.status = ST_BAD_CLOCK;
            end else if (!dvfs_en) begin
                r.target_clock = clk;
            end else begin
                // raise to the floor while powered, then cap at the ceiling
                tgt = clk;
                if (floor_eff > 0 && it.power_on && (tgt < floor_eff || cur < floor_eff))
                    tgt = floor_eff;
                if (ceil_eff > 0 && tgt > ceil_eff) tgt = ceil_eff;
                r.target_clock = tgt;
                lvl = lookup_level(tgt);
            end
        end else if (it.opcode == OP_TABLE_WR) begin
            if (it.table_index < TABLE_DEPTH) op_table[it.table_index] = clk;
        end
        r.floor_now   = floor_eff;
        r.ceiling_now = ceil_eff;
        r.level       = LVL_W'(lvl);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Queue one item and track table writes for later clock choices
    task automatic add_item(input t_opcode op, input logic [LT_IN_W-1:0] lt,
                            input logic [CLOCK_BITS-1:0] clk,
                            input logic [TIX_IN_W-1:0] tix, input logic pwr,
                            input logic [CLOCK_BITS-1:0] cur);
        t_action a;
        a.kind               = ACT_ITEM;
        a.item.opcode        = op;
        a.item.lock_type     = lt;
        a.item.clock_req     = clk;
        a.item.table_index   = tix;
        a.item.power_on      = pwr;
        a.item.current_clock = cur;
        a.idx                = CFG_DVFS_EN;
        a.data               = '0;
        if (op == OP_TABLE_WR) plan_table[tix] = clk;
        plan_q.push_back(a);
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [CLOCK_BITS-1:0] data);
        t_action a;
        a.kind = ACT_CFG;
        a.item = '0;
        a.idx  = idx;
        a.data = data;
        if (idx == CFG_TABLE_ENTRIES) plan_entries = data[TE_W-1:0];
        plan_q.push_back(a);
    endtask

    task automatic add_drain();
        t_action a;
        a.kind = ACT_DRAIN;
        a.item = '0;
        a.idx  = CFG_DVFS_EN;
        a.data = '0;
        plan_q.push_back(a);
    endtask

    // Mostly a clock from the searched part of the table, else anything
    function automatic logic [CLOCK_BITS-1:0] draw_clock();
        int n;
        n = (plan_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(plan_entries);
        if (n < 1) n = 1;
        case ($urandom_range(0, 9))
            0, 1:    return CLOCK_BITS'($urandom);
            2:       return plan_table[$urandom_range(0, TABLE_DEPTH - 1)];
            default: return plan_table[$urandom_range(0, n - 1)];
        endcase
    endfunction

    task automatic add_random_item();
        int                 r;
        t_opcode            op;
        logic [LT_IN_W-1:0] lt;
        r = $urandom_range(0, 99);
        if (r < 24)      op = OP_CEIL_LOCK;
        else if (r < 48) op = OP_FLOOR_LOCK;
        else if (r < 58) op = OP_CEIL_UNLOCK;
        else if (r < 68) op = OP_FLOOR_UNLOCK;
        else if (r < 94) op = OP_TARGET;
        else             op = OP_TABLE_WR;
        if ($urandom_range(0, 99) < 88) lt = LT_IN_W'($urandom_range(0, LOCK_TYPES - 1));
        else                            lt = LT_IN_W'($urandom_range(LOCK_TYPES, 15));
        add_item(op, lt, draw_clock(), TIX_IN_W'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)), draw_clock());
    endtask

    // Monitor: check results, predict accepted items, apply register writes
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cyc++;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.status         = o_m_tdata[1:0];
                got.floor_now      = o_m_tdata[23:2];
                got.ceiling_now    = o_m_tdata[45:24];
                got.target_clock   = o_m_tdata[67:46];
                got.level          = o_m_tdata[72:68];
                got.retarget_valid = o_m_tdata[73];
                got.retarget_clock = o_m_tdata[95:74];
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("floor_now", want.floor_now, got.floor_now);
                    check_field("ceiling_now", want.ceiling_now, got.ceiling_now);
                    check_field("target_clock", want.target_clock, got.target_clock);
                    check_field("level", want.level, got.level);
                    check_field("retarget_valid", want.retarget_valid, got.retarget_valid);
                    check_field("retarget_clock", want.retarget_clock, got.retarget_clock);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                awaited_results.push_back(arbitrate_item(cur_item));
                item_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DVFS_EN:       dvfs_en     = i_cfg_data[0];
                    CFG_MIN_CLOCK:     min_clk     = i_cfg_data;
                    CFG_MAX_CLOCK:     max_clk     = i_cfg_data;
                    CFG_USE_LIMIT:     use_limit   = i_cfg_data[0];
                    CFG_LIMIT_CLOCK:   limit_clk   = i_cfg_data;
                    CFG_TABLE_ENTRIES: tbl_entries = i_cfg_data[TE_W-1:0];
                    default: ;
                endcase
                cfg_taken = 1'b1;
            end
        end
    end

    // Driver: present planned items and register writes, idle at random
    always @(negedge i_clk) begin
        logic calm;
        calm = (cyc >= CALM_FROM && cyc < CALM_TO);
        if (item_taken) begin
            item_taken = 1'b0;
            item_hold  = 1'b0;
        end
        if (cfg_taken) begin
            cfg_taken = 1'b0;
            cfg_hold  = 1'b0;
        end
        if (i_rst_n && !item_hold && !cfg_hold && plan_q.size() > 0) begin
            case (plan_q[0].kind)
                ACT_ITEM: begin
                    if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
                        cur_item  = plan_q[0].item;
                        item_hold = 1'b1;
                        plan_q.delete(0);
                    end
                end
                ACT_CFG: begin
                    cfg_idx_r  = plan_q[0].idx;
                    cfg_data_r = plan_q[0].data;
                    cfg_hold   = 1'b1;
                    plan_q.delete(0);
                end
                default: begin
                    // hold off until every result is in, then let the block settle
                    if (awaited_results.size() == 0) begin
                        if (settle_cnt >= SETTLE) begin
                            settle_cnt = 0;
                            plan_q.delete(0);
                        end else begin
                            settle_cnt++;
                        end
                    end
                end
            endcase
        end
        i_s_tvalid  <= item_hold;
        i_s_tdata   <= {3'b000, cur_item.current_clock, cur_item.power_on,
                        cur_item.table_index, cur_item.clock_req, cur_item.lock_type};
        i_s_tuser   <= cur_item.opcode;
        i_cfg_valid <= cfg_hold;
        i_cfg_index <= cfg_idx_r;
        i_cfg_data  <= cfg_data_r;
        i_m_tready  <= i_rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // Run control: build the plan, release reset, wait for the drain
    initial begin
        int i;
        int p;
        for (i = 0; i < LOCK_TYPES; i++) begin
            ceil_by_type[i]  = '0;
            floor_by_type[i] = '0;
        end
        for (i = 0; i < TABLE_DEPTH; i++) begin
            op_table[i]   = '0;
            plan_table[i] = '0;
        end

        // load every operating point: zero at the bottom, all ones on top
        for (i = 0; i < TABLE_DEPTH; i++)
            add_item(OP_TABLE_WR, LT_IN_W'($urandom), (i == 0) ? '0 :
                     (i == TABLE_DEPTH - 1) ? CLK_TOP :
                     CLOCK_BITS'(i * 250000 + $urandom_range(0, 999)),
                     TIX_IN_W'(i), 1'($urandom), CLOCK_BITS'($urandom));

        // floor with no ceiling set: no retarget
        add_item(OP_FLOOR_LOCK, 4'd7, plan_table[1], 4'd0, 1'b1, '0);
        add_item(OP_CEIL_LOCK, 4'd0, CLK_TOP, 4'd15, 1'b0, '0);
        add_item(OP_CEIL_LOCK, 4'd1, CLK_TOP, 4'd0, 1'b1, CLK_TOP);
        add_item(OP_FLOOR_LOCK, 4'd6, plan_table[5], 4'd0, 1'b0, '0);
        // zero floor lock wipes the effective floor
        add_item(OP_FLOOR_LOCK, 4'd3, '0, 4'd0, 1'b0, '0);
        add_item(OP_FLOOR_LOCK, 4'd1, plan_table[6], 4'd0, 1'b1, plan_table[7]);
        add_item(OP_TARGET, 4'd0, plan_table[2], 4'd0, 1'b1, plan_table[9]);
        add_item(OP_TARGET, 4'd0, plan_table[2], 4'd0, 1'b0, plan_table[9]);
        add_item(OP_TARGET, 4'd0, plan_table[8], 4'd0, 1'b1, '0);
        add_item(OP_TARGET, 4'd0, 22'd1, 4'd0, 1'b1, '0);
        // ceiling below the floor caps the clamp
        add_item(OP_CEIL_LOCK, 4'd2, plan_table[4], 4'd0, 1'b1, plan_table[3]);
        add_item(OP_TARGET, 4'd5, plan_table[1], 4'd0, 1'b1, '0);
        add_item(OP_CEIL_LOCK, 4'd8, plan_table[4], 4'd0, 1'b1, '0);
        add_item(OP_FLOOR_UNLOCK, 4'd15, '0, 4'd0, 1'b1, '0);
        add_item(OP_CEIL_LOCK, 4'd3, plan_table[4] + 1'b1, 4'd0, 1'b1, '0);
        add_item(OP_CEIL_UNLOCK, 4'd2, '0, 4'd0, 1'b0, '0);
        add_item(OP_CEIL_UNLOCK, 4'd0, '0, 4'd0, 1'b0, '0);
        add_item(OP_CEIL_LOCK, 4'd1, '0, 4'd0, 1'b0, CLK_TOP);
        add_item(OP_FLOOR_UNLOCK, 4'd1, '0, 4'd0, 1'b0, '0);
        add_item(OP_FLOOR_UNLOCK, 4'd7, '0, 4'd0, 1'b0, '0);

        // dvfs off: locks ignored, targets pass unclamped
        add_drain();
        add_cfg(CFG_DVFS_EN, '0);
        add_item(OP_CEIL_LOCK, 4'd0, plan_table[3], 4'd0, 1'b1, CLK_TOP);
        add_item(OP_CEIL_UNLOCK, 4'd9, '0, 4'd0, 1'b1, '0);
        add_item(OP_TARGET, 4'd0, plan_table[12], 4'd0, 1'b1, '0);

        // random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            add_drain();
            case (p)
                0: begin
                    add_cfg(CFG_DVFS_EN, 22'd1);
                    add_cfg(CFG_MIN_CLOCK, '0);
                    add_cfg(CFG_MAX_CLOCK, CLK_TOP);
                    add_cfg(CFG_USE_LIMIT, '0);
                    add_cfg(CFG_LIMIT_CLOCK, CLK_TOP);
                    add_cfg(CFG_TABLE_ENTRIES, 22'd16);
                end
                1: begin
                    add_cfg(CFG_MIN_CLOCK, plan_table[3]);
                    add_cfg(CFG_MAX_CLOCK, plan_table[12]);
                end
                2: begin
                    add_cfg(CFG_MIN_CLOCK, '0);
                    add_cfg(CFG_MAX_CLOCK, CLK_TOP);
                    add_cfg(CFG_USE_LIMIT, 22'd1);
                    add_cfg(CFG_LIMIT_CLOCK, plan_table[9]);
                    add_cfg(CFG_TABLE_ENTRIES, 22'd12);
                end
                3: begin
                    add_cfg(CFG_USE_LIMIT, '0);
                    add_cfg(CFG_MAX_CLOCK, plan_table[10]);
                    add_cfg(CFG_TABLE_ENTRIES, 22'd1);
                end
                4: begin
                    add_cfg(CFG_MIN_CLOCK, CLK_TOP);
                    add_cfg(CFG_MAX_CLOCK, CLK_TOP);
                    add_cfg(CFG_TABLE_ENTRIES, 22'd16);
                end
                5: begin
                    add_cfg(CFG_MIN_CLOCK, '0);
                    add_cfg(CFG_USE_LIMIT, 22'd1);
                    add_cfg(CFG_LIMIT_CLOCK, '0);
                end
                6: begin
                    add_cfg(CFG_DVFS_EN, '0);
                    add_cfg(CFG_USE_LIMIT, '0);
                end
                default: begin
                    add_cfg(CFG_DVFS_EN, ($urandom_range(0, 99) < 85) ? 22'd1 : 22'd0);
                    add_cfg(CFG_MIN_CLOCK, $urandom_range(0, 1) ? '0 :
                            plan_table[$urandom_range(0, TABLE_DEPTH - 1)]);
                    add_cfg(CFG_MAX_CLOCK, $urandom_range(0, 1) ? CLK_TOP :
                            plan_table[$urandom_range(0, TABLE_DEPTH - 1)]);
                    add_cfg(CFG_USE_LIMIT, 22'($urandom_range(0, 1)));
                    add_cfg(CFG_LIMIT_CLOCK, $urandom_range(0, 1) ? CLK_TOP :
                            plan_table[$urandom_range(0, TABLE_DEPTH - 1)]);
                    add_cfg(CFG_TABLE_ENTRIES, 22'($urandom_range(1, TABLE_DEPTH)));
                end
            endcase
            repeat (PHASE_ITEMS) add_random_item();
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (plan_q.size() > 0 || item_hold || cfg_hold || awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("tb_dvfs_clock_lock_arbiter: done, clean");
        else
            $display("tb_dvfs_clock_lock_arbiter: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_dvfs_clock_lock_arbiter: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/dcla_pkg.sv
rtl/core/dcla_ctrl.sv
rtl/core/dcla_dp.sv
rtl/core/dvfs_clock_lock_arbiter.sv
tb/tb_dvfs_clock_lock_arbiter.sv
